### sv/assert_macros.svh
// Assertion macros shared by the RTL of the ready table.
// Self-contained; each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define RMRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define RMRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/rmrt_pkg.sv
// Shared types and constants for the rate-monotonic ready table.
// No dependencies.
package rmrt_pkg;

  localparam int PID_W       = 16;
  localparam int PERIOD_W    = 32;
  localparam int STAMP_W     = 32;
  localparam int OPC_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_DEF   = 16;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 56;

  // Opcodes
  localparam logic [OPC_W-1:0] OP_REGISTER = 3'd0;
  localparam logic [OPC_W-1:0] OP_SCHEDULE = 3'd1;
  localparam logic [OPC_W-1:0] OP_SWITCH   = 3'd2;
  localparam logic [OPC_W-1:0] OP_REQUEUE  = 3'd3;
  localparam logic [OPC_W-1:0] OP_REMOVE   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOPREV   = 2'd3;

  // One table slot as stored in the slot RAM
  typedef struct packed {
    logic [PID_W-1:0]    pid;
    logic [PERIOD_W-1:0] period;
    logic [STAMP_W-1:0]  stamp;
  } rmrt_entry_t;

  localparam int ENTRY_W = PID_W + PERIOD_W + STAMP_W;

endpackage

### sv/rmrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rmrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/rate_monotonic_ready_table.sv
// Rate-monotonic ready table: one item per scan of all slots.
// Each item passes the SCAN, DRAIN and DONE states; a stalled output holds
// DONE. New items are taken only in IDLE. The slot RAM read port visits
// one slot per cycle and a single compare unit ranks it.
// Reset (rst_n low, synchronous) empties the table and restores the init task.
// Depends on rmrt_pkg, rmrt_ram and assert_macros.svh.
`include "assert_macros.svh"

module rate_monotonic_ready_table
  import rmrt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration: init_pid
  input  logic                  cfg_we,
  input  logic [PID_W-1:0]      cfg_wdata,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] task_pid, [47:16] task_period
  input  logic [OPC_W-1:0]      in_tuser,   // [2:0] opcode
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [1:0] status, [2] switched,
                                            // [18:3] run_pid, [50:19] run_period
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]             state_r;
  logic [IDX_W-1:0]       scan_cnt_r;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_idx_r;

  logic [OPC_W-1:0]       op_r;
  logic [PID_W-1:0]       op_pid_r;
  logic [PERIOD_W-1:0]    op_period_r;

  logic                   best_found_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [PID_W-1:0]       best_pid_r;
  logic [PERIOD_W-1:0]    best_period_r;
  logic [STAMP_W-1:0]     best_stamp_r;
  logic                   free_found_r;
  logic [IDX_W-1:0]       free_idx_r;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [STAMP_W-1:0]     arrival_r;
  logic                   init_run_r;
  logic [PID_W-1:0]       run_pid_r;
  logic [PERIOD_W-1:0]    run_period_r;
  logic                   prev_vld_r;
  logic [PID_W-1:0]       prev_pid_r;
  logic [PERIOD_W-1:0]    prev_period_r;

  logic                   out_tvalid_r;
  logic [OUT_DATA_W-1:0]  out_tdata_r;

  // slot RAM
  rmrt_entry_t            rd_entry;
  rmrt_entry_t            wr_entry;
  logic                   ram_we;

  logic                   in_acc;
  logic                   done_go;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign done_go   = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  rmrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (wr_entry),
    .re    (state_r == S_SCAN),
    .raddr (scan_cnt_r),
    .rdata (rd_entry)
  );

  // Shared rank unit: does the slot just read beat the current best
  logic                cand_ok;
  logic                cand_ahead;
  logic [STAMP_W-1:0]  stamp_diff;

  always_comb begin
    stamp_diff = rd_entry.stamp - best_stamp_r;
    cand_ok    = rd_vld_r && valid_r[rd_idx_r] &&
                 ((op_r != OP_REMOVE) || (rd_entry.pid == op_pid_r));
    // equal stamps keep the lower index, which is already the best
    cand_ahead = (rd_entry.period < best_period_r) ||
                 ((rd_entry.period == best_period_r) && stamp_diff[STAMP_W-1]);
  end

  // Decision at the end of the scan
  logic                ins_req;
  logic                ins_ok;
  logic                take;
  logic                remove_ok;
  logic [STATUS_W-1:0] status;
  logic [PID_W-1:0]    run_pid_nxt;
  logic [PERIOD_W-1:0] run_period_nxt;

  always_comb begin
    ins_req   = (op_r == OP_REGISTER) || ((op_r == OP_REQUEUE) && prev_vld_r);
    ins_ok    = ins_req && free_found_r;
    take      = best_found_r &&
                (((op_r == OP_SCHEDULE) && (best_period_r <= run_period_r)) ||
                 (op_r == OP_SWITCH));
    remove_ok = (op_r == OP_REMOVE) && best_found_r;
    unique case (op_r)
      OP_REGISTER: status = free_found_r ? ST_OK : ST_FULL;
      OP_REQUEUE:  status = !prev_vld_r ? ST_NOPREV : (free_found_r ? ST_OK : ST_FULL);
      OP_REMOVE:   status = best_found_r ? ST_OK : ST_NOTFOUND;
      default:     status = ST_OK;
    endcase
    run_pid_nxt    = take ? best_pid_r : run_pid_r;
    run_period_nxt = take ? best_period_r : run_period_r;
    wr_entry.pid    = (op_r == OP_REQUEUE) ? prev_pid_r : op_pid_r;
    wr_entry.period = (op_r == OP_REQUEUE) ? prev_period_r : op_period_r;
    wr_entry.stamp  = arrival_r;
  end

  assign ram_we = done_go && ins_ok;

  // Sequencer, scan bookkeeping and scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rd_vld_r      <= 1'b0;
      valid_r       <= '0;
      arrival_r     <= '0;
      init_run_r    <= 1'b1;
      run_pid_r     <= '0;
      run_period_r  <= '1;
      prev_vld_r    <= 1'b0;
      prev_pid_r    <= '0;
      prev_period_r <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_SCAN);
      rd_idx_r <= scan_cnt_r;

      // rank the slot read in the previous cycle
      if (cand_ok && (!best_found_r || cand_ahead)) begin
        best_found_r  <= 1'b1;
        best_idx_r    <= rd_idx_r;
        best_pid_r    <= rd_entry.pid;
        best_period_r <= rd_entry.period;
        best_stamp_r  <= rd_entry.stamp;
      end
      // lowest free slot
      if (rd_vld_r && !valid_r[rd_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end

      // result taken and no new one loaded this cycle
      if (out_tvalid_r && out_tready && !done_go) begin
        out_tvalid_r <= 1'b0;
      end

      if (cfg_we) begin
        if (init_run_r) begin
          run_pid_r <= cfg_wdata;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r         <= in_tuser;
            op_pid_r     <= in_tdata[PID_W-1:0];
            op_period_r  <= in_tdata[PID_W +: PERIOD_W];
            scan_cnt_r   <= '0;
            best_found_r <= 1'b0;
            free_found_r <= 1'b0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
          if (scan_cnt_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (done_go) begin
            state_r <= S_IDLE;
            if (ins_ok) begin
              valid_r[free_idx_r] <= 1'b1;
              arrival_r           <= arrival_r + 1'b1;
              if (op_r == OP_REQUEUE) begin
                prev_vld_r <= 1'b0;
              end
            end
            if (take || remove_ok) begin
              valid_r[best_idx_r] <= 1'b0;
            end
            if (take) begin
              run_pid_r    <= best_pid_r;
              run_period_r <= best_period_r;
              init_run_r   <= 1'b0;
              if (op_r == OP_SCHEDULE) begin
                prev_vld_r    <= 1'b1;
                prev_pid_r    <= run_pid_r;
                prev_period_r <= run_period_r;
              end else begin
                prev_vld_r <= 1'b0;
              end
            end
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {{(OUT_DATA_W - STATUS_W - 1 - PID_W - PERIOD_W){1'b0}},
                             run_period_nxt, run_pid_nxt, take, status};
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  `RMRT_ASSERT_NEXT(a_accept_starts_scan, in_acc, state_r == S_SCAN, "accept did not start a scan")
  `RMRT_ASSERT(a_write_free_slot, !ram_we || !valid_r[free_idx_r], "insert into an occupied slot")
  `RMRT_ASSERT_NEXT(a_stamp_advance, ram_we, arrival_r == $past(arrival_r) + 1'b1, "stamp not advanced")
  `RMRT_ASSERT_NEXT(a_result_after_done, done_go, out_tvalid_r && (state_r == S_IDLE), "result lost")

endmodule

### dv/tb_rate_monotonic_ready_table.sv
// Self-checking testbench for rate_monotonic_ready_table: a local scheduler
// model predicts status, switch flag and running task for every item.
// Depends on rmrt_pkg and the RTL of the block.
module tb_rate_monotonic_ready_table;
  import rmrt_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int LATENCY = DEPTH + 3;
  // opcodes the block treats as no operation
  localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                switched;
    logic [PID_W-1:0]    run_pid;
    logic [PERIOD_W-1:0] run_period;
  } sched_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [PID_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [15:0] task_pid, [47:16] task_period
  logic [OPC_W-1:0]      in_tuser = '0;   // [2:0] opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [1:0] status, [2] switched,
                                          // [18:3] run_pid, [50:19] run_period

  rate_monotonic_ready_table #(.TABLE_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  // scheduler model state
  bit                  tbl_valid  [DEPTH];
  logic [PID_W-1:0]    tbl_pid    [DEPTH];
  logic [PERIOD_W-1:0] tbl_period [DEPTH];
  logic [STAMP_W-1:0]  tbl_stamp  [DEPTH];
  logic [STAMP_W-1:0]  arrivals;
  logic [PID_W-1:0]    cur_pid;
  logic [PERIOD_W-1:0] cur_period;
  bit                  pre_valid;
  logic [PID_W-1:0]    pre_pid;
  logic [PERIOD_W-1:0] pre_period;
  bit                  boot_running;

  sched_result_t pending_results[$];
  int            fault_count = 0;
  bit            gaps_on = 1'b1;
  int            stall_left = 0;

  function automatic void model_reset();
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    arrivals     = '0;
    cur_pid      = '0;
    cur_period   = '1;
    pre_valid    = 1'b0;
    pre_pid      = '0;
    pre_period   = '0;
    boot_running = 1'b1;
  endfunction

  function automatic void model_config(logic [PID_W-1:0] v);
    if (boot_running) cur_pid = v;
  endfunction

  // shorter period first, then earlier stamp (mod 2^32), then lower index
  function automatic bit slot_ahead(int a, int b);
    logic [STAMP_W-1:0] d;
    if (tbl_period[a] != tbl_period[b]) return tbl_period[a] < tbl_period[b];
    d = tbl_stamp[a] - tbl_stamp[b];
    if (d != '0) return d[STAMP_W-1];
    return a < b;
  endfunction

  function automatic int pick_head(bit by_pid, logic [PID_W-1:0] pid);
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_valid[i] && (!by_pid || tbl_pid[i] == pid)) begin
        if (best < 0 || slot_ahead(i, best)) best = i;
      end
    end
    return best;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) n += tbl_valid[i];
    return n;
  endfunction

  function automatic logic [STATUS_W-1:0] table_insert(logic [PID_W-1:0] pid,
                                                       logic [PERIOD_W-1:0] per);
    for (int i = 0; i < DEPTH; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i]  = 1'b1;
        tbl_pid[i]    = pid;
        tbl_period[i] = per;
        tbl_stamp[i]  = arrivals;
        arrivals      = arrivals + 1'b1;
        return ST_OK;
      end
    end
    return ST_FULL;
  endfunction

  function automatic void take_slot(int h);
    cur_pid      = tbl_pid[h];
    cur_period   = tbl_period[h];
    tbl_valid[h] = 1'b0;
    boot_running = 1'b0;
  endfunction

  function automatic sched_result_t model_step(logic [OPC_W-1:0] opc,
                                               logic [PID_W-1:0] pid,
                                               logic [PERIOD_W-1:0] per);
    sched_result_t res;
    int h;
    res.status   = ST_OK;
    res.switched = 1'b0;
    case (opc)
      OP_REGISTER: res.status = table_insert(pid, per);
      OP_SCHEDULE: begin
        h = pick_head(1'b0, '0);
        if (h >= 0 && tbl_period[h] <= cur_period) begin
          pre_valid  = 1'b1;
          pre_pid    = cur_pid;
          pre_period = cur_period;
          take_slot(h);
          res.switched = 1'b1;
        end
      end
      OP_SWITCH: begin
        h = pick_head(1'b0, '0);
        if (h >= 0) begin
          pre_valid = 1'b0;
          take_slot(h);
          res.switched = 1'b1;
        end
      end
      OP_REQUEUE: begin
        if (!pre_valid) begin
          res.status = ST_NOPREV;
        end else begin
          res.status = table_insert(pre_pid, pre_period);
          if (res.status == ST_OK) pre_valid = 1'b0;
        end
      end
      OP_REMOVE: begin
        h = pick_head(1'b1, pid);
        if (h >= 0) tbl_valid[h] = 1'b0;
        else res.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    res.run_pid    = cur_pid;
    res.run_period = cur_period;
    return res;
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(15, 70);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 99) < 15) begin
      stall_left <= pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fault_count++;
    end
  endfunction

  // compare each accepted result item with the oldest prediction
  always @(posedge clk) begin : result_check
    sched_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        field_check("status", 32'(want.status), 32'(out_tdata[1:0]));
        field_check("switched", 32'(want.switched), 32'(out_tdata[2]));
        field_check("run_pid", 32'(want.run_pid), 32'(out_tdata[18:3]));
        field_check("run_period", want.run_period, out_tdata[50:19]);
      end
    end
  end

  // Valid stays high after acceptance; the next call either replaces the item
  // in the same step or drops valid for its gap.
  task automatic send_item(input logic [OPC_W-1:0] opc, input logic [PID_W-1:0] pid,
                           input logic [PERIOD_W-1:0] per);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= opc;
    in_tdata  <= {per, pid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(model_step(opc, pid, per));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // init_pid write, only with the block idle
  task automatic write_init_pid(input logic [PID_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    model_config(v);
    cfg_we    <= 1'b0;
  endtask

  // empty table: init task visible, nothing to schedule or remove
  task automatic test_boot_task();
    write_init_pid(16'hffff);
    send_item(OP_SCHEDULE, '0, '0);
    send_item(OP_SWITCH, '0, '0);
    write_init_pid(16'h1357);
    // the running task is never removed
    send_item(OP_REMOVE, 16'h1357, '0);
    send_item(OP_SPARE_LO, '1, '1);
    send_item(OP_SPARE_HI, '0, '0);
  endtask

  task automatic test_basic_ops();
    // equal period preempts the init task
    send_item(OP_REGISTER, 16'hffff, 32'hffff_ffff);
    send_item(OP_SCHEDULE, '0, '0);
    send_item(OP_REQUEUE, '0, '0);
    send_item(OP_REQUEUE, '0, '0);
    // duplicate pids: the one nearest the head goes first
    send_item(OP_REGISTER, 16'h0000, 32'h0000_0000);
    send_item(OP_REGISTER, 16'h0000, 32'h0000_0000);
    send_item(OP_REMOVE, 16'h0000, '0);
    send_item(OP_SCHEDULE, '0, '0);
    // longer head period does not preempt
    send_item(OP_REGISTER, 16'h5555, 32'h0000_0001);
    send_item(OP_SCHEDULE, '0, '0);
    // exit takes the head if the table holds one and drops the preempted record
    send_item(OP_SWITCH, '0, '0);
    send_item(OP_REQUEUE, '0, '0);
  endtask

  task automatic test_table_full();
    int i;
    i = 0;
    send_item(OP_REGISTER, 16'h0007, 32'h0000_0000);
    send_item(OP_SCHEDULE, '0, '0);
    while (live_count() < DEPTH) begin
      send_item(OP_REGISTER, 16'h0100 + i[PID_W-1:0], $urandom_range(1, 6) * 100);
      i++;
    end
    send_item(OP_REGISTER, 16'hbeef, 32'd5);
    // failed requeue keeps the preempted task for a retry
    send_item(OP_REQUEUE, '0, '0);
    send_item(OP_REMOVE, 16'h0100, '0);
    send_item(OP_REQUEUE, '0, '0);
    send_item(OP_REQUEUE, '0, '0);
  endtask

  function automatic logic [PID_W-1:0] pick_pid(bit prefer_live);
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (prefer_live && live_count() > 0 && r < 75) begin
      k = $urandom_range(0, live_count() - 1);
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_valid[i]) begin
          if (k == 0) return tbl_pid[i];
          k--;
        end
      end
    end
    if (r < 60) return PID_W'($urandom_range(0, 23));
    if (r < 70) return cur_pid;
    return PID_W'($urandom_range(0, 65535));
  endfunction

  // many ties among periods, some matching the running task, some extremes
  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(1, 6) * 100;
    if (r < 55) return cur_period;
    if (r < 62) return '0;
    if (r < 69) return '1;
    return $urandom();
  endfunction

  task automatic test_random_mix(input int n_items, input int w_reg, input int w_sched,
                                 input int w_switch, input int w_requeue, input int w_remove);
    int r;
    logic [OPC_W-1:0] opc;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, w_reg + w_sched + w_switch + w_requeue + w_remove + 2);
      if (r < w_reg) opc = OP_REGISTER;
      else if (r < w_reg + w_sched) opc = OP_SCHEDULE;
      else if (r < w_reg + w_sched + w_switch) opc = OP_SWITCH;
      else if (r < w_reg + w_sched + w_switch + w_requeue) opc = OP_REQUEUE;
      else if (r < w_reg + w_sched + w_switch + w_requeue + w_remove) opc = OP_REMOVE;
      else opc = OPC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      send_item(opc, pick_pid(opc == OP_REMOVE), pick_period());
    end
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_boot_task();
    test_basic_ops();
    test_table_full();
    // random phases: balanced, filling, draining, preempt heavy
    write_init_pid(16'h0000);
    test_random_mix(250, 30, 20, 15, 15, 15);
    write_init_pid(16'hffff);
    gaps_on = 1'b0;
    test_random_mix(200, 50, 15, 5, 20, 5);
    write_init_pid(PID_W'($urandom_range(0, 65535)));
    gaps_on = 1'b1;
    test_random_mix(250, 20, 20, 25, 10, 25);
    write_init_pid(PID_W'($urandom_range(0, 65535)));
    gaps_on = 1'b0;
    test_random_mix(200, 30, 20, 15, 15, 15);
    write_init_pid(16'h8001);
    gaps_on = 1'b1;
    test_random_mix(250, 30, 30, 10, 20, 10);
    drain_results();
    repeat (3 * LATENCY) @(posedge clk);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
